/* rtl/ptpd_pkg.sv */
// Package for the point transform with perspective divide.
// Holds the item types, the register count and the reset matrix.
// No dependencies.
package ptpd_pkg;

    localparam int NUM_COEF = 8;
    localparam int IDX_W = 8;
    localparam int CFG_W = 64;

    localparam logic [CFG_W-1:0] COEF_RESET [NUM_COEF] = '{
        64'd65536, 64'd0, 64'd281474976710656, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'd281474976710656
    };

    typedef struct packed {
        logic               mode;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } point_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               divide_fault;
        logic               saturated;
    } result_t;

endpackage

/* rtl/point_transform_perspective_divide_top.sv */
// Top level of the point transform with perspective divide.
// Depends on ptpd_pkg for item types and reset coefficients.
//
// Usage:
// A point item enters on point/point_valid and is taken at a clock edge where
// point_valid is high and point_stall is low. The result item leaves on
// result/result_valid and is taken when result_valid is high and result_stall
// is low. The 4x4 matrix is written through cfg_we, cfg_index and cfg_wdata;
// the user must write it only while the block is idle; the block does not
// enforce this. An index of eight or more is ignored. An item passes one
// multiply stage, one row sum stage, one clip stage, one restoring divide step
// per quotient bit (32 + FRAC_BITS steps) and one output stage. Throughput is
// one item per cycle unless the output stalls; every stage is a register with
// a valid bit, and bubbles are squeezed out while the output waits.
// Reset clears all valid bits and loads the identity matrix.
// When the receiver stalls, the result holds and the stages behind it keep
// filling; point_stall rises only once every stage holds an item.
module point_transform_perspective_divide_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   point_valid,
    output logic                   point_stall,
    input  ptpd_pkg::point_t       point,
    output logic                   result_valid,
    input  logic                   result_stall,
    output ptpd_pkg::result_t      result,
    input  logic                   cfg_we,
    input  logic [ptpd_pkg::IDX_W-1:0] cfg_index,
    input  logic [ptpd_pkg::CFG_W-1:0] cfg_wdata
);
    import ptpd_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int SW = 67;
    localparam logic signed [31:0] ONE = 32'(1) << FRAC_BITS;
    localparam logic signed [SW-1:0] S_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] S_MIN = -SW'(64'sd2147483648);

    typedef struct packed {
        logic [2:0][31:0]   rem;
        logic [2:0][NW-1:0] num;
        logic [2:0][NW-1:0] quo;
        logic [31:0]        den;
        logic [2:0]         neg;
        logic               fault;
        logic               sat;
    } div_t;

    logic [CFG_W-1:0] coef_reg [NUM_COEF];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COEF; k++)
            begin
                coef_reg[k] <= COEF_RESET[k];
            end
        end
        else if (cfg_we && cfg_index < IDX_W'(NUM_COEF))
        begin
            coef_reg[cfg_index[2:0]] <= cfg_wdata;
        end
    end

    logic signed [31:0] m [16];
    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            m[k] = coef_reg[k/2][(k%2)*32 +: 32];
        end
    end

    // Enables, back to front.
    logic           v0_reg, v1_reg, vo_reg;
    logic [NW:0]    dv_reg;
    logic           en0, en1, eno;
    logic [NW:0]    en_d;

    assign eno = !vo_reg || !result_stall;
    assign en_d[NW] = !dv_reg[NW] || eno;
    genvar g;
    generate
        for (g = 0; g < NW; g++)
        begin : g_en
            assign en_d[g] = !dv_reg[g] || en_d[g+1];
        end
    endgenerate
    assign en1 = !v1_reg || en_d[0];
    assign en0 = !v0_reg || en1;
    assign point_stall = !en0;

    // Stage 0: products.
    logic signed [63:0] prod_reg [4][3];
    logic signed [31:0] m3_reg [4];
    logic signed [31:0] pz;
    assign pz = point.mode ? ONE : point.in_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en0)
        begin
            v0_reg <= point_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            for (int r = 0; r < 4; r++)
            begin
                prod_reg[r][0] <= 64'(point.in_x) * 64'(m[4*r]);
                prod_reg[r][1] <= 64'(point.in_y) * 64'(m[4*r+1]);
                prod_reg[r][2] <= 64'(pz) * 64'(m[4*r+2]);
                m3_reg[r] <= m[4*r+3];
            end
        end
    end

    // Stage 1: exact row sums.
    logic signed [SW-1:0] sum_reg [4];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sum_reg[r] <= SW'(prod_reg[r][0]) + SW'(prod_reg[r][1])
                            + SW'(prod_reg[r][2]) + (SW'(m3_reg[r]) <<< FRAC_BITS);
            end
        end
    end

    // Stage 2: floor shift, clip, magnitudes for the divider.
    div_t dq_reg [NW+1];
    div_t clip_next;
    always_comb
    begin
        logic signed [SW-1:0] sh;
        logic signed [31:0]   s [4];
        logic [31:0]          mag [4];
        clip_next = '0;
        for (int r = 0; r < 4; r++)
        begin
            sh = sum_reg[r] >>> FRAC_BITS;
            if (sh > S_MAX)
            begin
                s[r] = 32'sh7fffffff;
                clip_next.sat = 1'b1;
            end
            else if (sh < S_MIN)
            begin
                s[r] = 32'sh80000000;
                clip_next.sat = 1'b1;
            end
            else
            begin
                s[r] = sh[31:0];
            end
            mag[r] = s[r][31] ? (~s[r] + 32'd1) : s[r];
        end
        clip_next.fault = (s[3] == 32'sd0);
        clip_next.den = mag[3];
        for (int j = 0; j < 3; j++)
        begin
            clip_next.num[j] = {mag[j], {FRAC_BITS{1'b0}}};
            clip_next.neg[j] = s[j][31] ^ s[3][31];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else if (en_d[0])
        begin
            dv_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_d[0])
        begin
            dq_reg[0] <= clip_next;
        end
    end

    // Restoring divide, one quotient bit per stage.
    generate
        for (g = 0; g < NW; g++)
        begin : g_div
            div_t step_next;
            always_comb
            begin
                logic [32:0] t;
                step_next = dq_reg[g];
                for (int j = 0; j < 3; j++)
                begin
                    t = {dq_reg[g].rem[j], dq_reg[g].num[j][NW-1]};
                    step_next.num[j] = dq_reg[g].num[j] << 1;
                    if (t >= {1'b0, dq_reg[g].den})
                    begin
                        step_next.rem[j] = 32'(t - {1'b0, dq_reg[g].den});
                        step_next.quo[j] = {dq_reg[g].quo[j][NW-2:0], 1'b1};
                    end
                    else
                    begin
                        step_next.rem[j] = t[31:0];
                        step_next.quo[j] = {dq_reg[g].quo[j][NW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_reg[g+1] <= 1'b0;
                end
                else if (en_d[g+1])
                begin
                    dv_reg[g+1] <= dv_reg[g];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en_d[g+1])
                begin
                    dq_reg[g+1] <= step_next;
                end
            end
        end
    endgenerate

    // Output stage: sign, clip, fault.
    result_t res_next, res_reg;
    always_comb
    begin
        logic [NW-1:0] lim;
        logic [31:0]   val [3];
        logic          sat;
        sat = dq_reg[NW].sat;
        for (int j = 0; j < 3; j++)
        begin
            lim = dq_reg[NW].neg[j] ? NW'(33'h080000000) : NW'(33'h07fffffff);
            if (dq_reg[NW].quo[j] > lim)
            begin
                val[j] = dq_reg[NW].neg[j] ? 32'h80000000 : 32'h7fffffff;
                sat = sat || !dq_reg[NW].fault;
            end
            else if (dq_reg[NW].neg[j])
            begin
                val[j] = ~dq_reg[NW].quo[j][31:0] + 32'd1;
            end
            else
            begin
                val[j] = dq_reg[NW].quo[j][31:0];
            end
        end
        res_next.divide_fault = dq_reg[NW].fault;
        res_next.saturated = sat;
        res_next.out_x = dq_reg[NW].fault ? 32'sd0 : val[0];
        res_next.out_y = dq_reg[NW].fault ? 32'sd0 : val[1];
        res_next.out_z = dq_reg[NW].fault ? 32'sd0 : val[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (eno)
        begin
            vo_reg <= dv_reg[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (eno)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = vo_reg;
    assign result = res_reg;

endmodule

/* rtl/ptpd_checker.sv */
// Port-level checker for the point transform top level, and its bind.
// Depends on ptpd_pkg for the result type.
module ptpd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                point_stall,
    input logic                result_valid,
    input logic                result_stall,
    input ptpd_pkg::result_t   result
);
    import ptpd_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("Stalled result changed.");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.divide_fault |->
            result.out_x == 32'sd0 && result.out_y == 32'sd0 && result.out_z == 32'sd0)
        else $error("Fault result carries nonzero coordinates.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> result_valid && result_stall)
        else $error("Input stalled without output backpressure.");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("Result valid right after reset.");

endmodule

bind point_transform_perspective_divide_top ptpd_checker u_ptpd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_stall  (point_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
